// ===== rtl/rnpr_pkg.sv =====
// Shared constants, codes and controller/datapath handshake structs for the
// RIST null-packet restore planner. No dependencies.
package rnpr_pkg;

  localparam int PLEN_W = 11;
  localparam int HLEN_W = 10;
  localparam int SEQ_W  = 32;
  localparam int IDX_W  = 4;
  localparam int SIZE_W = 8;
  localparam int NPD_W  = 7;

  localparam logic [15:0]       RIST_PROFILE   = 16'h5249;  // "RI"
  localparam logic [15:0]       RIST_EXT_WORDS = 16'd1;
  localparam logic [SEQ_W-1:0]  STALE_LIMIT    = 32'd32767;
  localparam logic [SIZE_W-1:0] TS_SIZE_SHORT  = 8'd188;
  localparam logic [SIZE_W-1:0] TS_SIZE_LONG   = 8'd204;
  localparam logic [IDX_W-1:0]  MAX_TS_ENTRIES = 4'd14;
  localparam logic [HLEN_W-1:0] EXT_HDR_BYTES  = 10'd8;

  typedef enum logic [1:0] {
    ACT_PASS  = 2'd0,
    ACT_DROP  = 2'd1,
    ACT_STRIP = 2'd2,
    ACT_ENTRY = 2'd3
  } action_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic take;         // input port open
    logic decode;       // classify the latched request, update sequence state
    logic div_step;     // one subtract step of the size/count divider
    logic plan;         // latch TS size and packet count
    logic emit_single;  // load the one-result answer into the output register
    logic emit_entry;   // load the next TS entry into the output register
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic in_fire;
    logic single;
    logic div_done;
    logic size_bad;
    logic out_free;
    logic last_entry;
  } status_t;

endpackage

// ===== rtl/rnpr_if.sv =====
// Valid/ready channel interfaces for request and result items.
// Depends on rnpr_pkg.
interface rnpr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        has_extension;
  logic [15:0]                 ext_profile;
  logic [15:0]                 ext_words;
  logic [7:0]                  ext_byte0;
  logic [7:0]                  ext_byte1;
  logic [15:0]                 seq_high;
  logic [15:0]                 rtp_seq;
  logic [rnpr_pkg::PLEN_W-1:0] payload_len;
  logic [rnpr_pkg::HLEN_W-1:0] header_len;

  modport source (
    output valid, has_extension, ext_profile, ext_words, ext_byte0, ext_byte1,
           seq_high, rtp_seq, payload_len, header_len,
    input  ready
  );
  modport sink (
    input  valid, has_extension, ext_profile, ext_words, ext_byte0, ext_byte1,
           seq_high, rtp_seq, payload_len, header_len,
    output ready
  );
endinterface

interface rnpr_out_if;
  logic                        valid;
  logic                        ready;
  rnpr_pkg::action_t           action;
  logic [rnpr_pkg::IDX_W-1:0]  ts_index;
  logic                        is_null;
  logic [rnpr_pkg::PLEN_W-1:0] copy_offset;
  logic                        copy_ok;
  logic [rnpr_pkg::SIZE_W-1:0] ts_size;
  logic [rnpr_pkg::IDX_W-1:0]  packet_count;
  logic [rnpr_pkg::HLEN_W-1:0] stripped_header_len;
  logic [rnpr_pkg::SEQ_W-1:0]  max_seq_seen;
  logic                        ext_seq_seen;
  logic                        last;

  modport source (
    output valid, action, ts_index, is_null, copy_offset, copy_ok, ts_size,
           packet_count, stripped_header_len, max_seq_seen, ext_seq_seen, last,
    input  ready
  );
  modport sink (
    input  valid, action, ts_index, is_null, copy_offset, copy_ok, ts_size,
           packet_count, stripped_header_len, max_seq_seen, ext_seq_seen, last,
    output ready
  );
endinterface

// ===== rtl/rnpr_ctrl.sv =====
// Sequencing state machine of the restore planner.
// Depends on rnpr_pkg; drives cmd_t, reads status_t.
module rnpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  rnpr_pkg::status_t status,
  output rnpr_pkg::cmd_t    cmd
);
  import rnpr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_DIV    = 5'b00100,
    S_SINGLE = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (status.in_fire) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = status.single ? S_SINGLE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          if (status.size_bad) begin
            state_nxt = S_SINGLE;
          end else begin
            cmd.plan  = 1'b1;
            state_nxt = S_EMIT;
          end
        end
      end
      S_SINGLE: begin
        if (status.out_free) begin
          cmd.emit_single = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_entry = 1'b1;
          if (status.last_entry) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== rtl/rnpr_dp.sv =====
// Datapath of the restore planner: request latch, sequence state, size
// divider, entry walker and output register. Depends on rnpr_pkg, rnpr_if.
module rnpr_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  rnpr_pkg::cmd_t    cmd,
  output rnpr_pkg::status_t status,
  rnpr_in_if.sink           in_chan,
  rnpr_out_if.source        out_chan
);
  import rnpr_pkg::*;

  // Latched request
  logic               has_ext_r;
  logic [15:0]        profile_r, words_r, seqh_r, seq_r;
  logic [7:0]         byte0_r, byte1_r;
  logic [PLEN_W-1:0]  plen_r;
  logic [HLEN_W-1:0]  hlen_r;

  // Sequence state
  logic [SEQ_W-1:0]   max_r, max_nxt;
  logic               eflag_r, eflag_nxt;

  // Work registers
  action_t            kind_r;
  logic [SIZE_W-1:0]  size_r;
  logic [PLEN_W-1:0]  rem188_r, rem204_r;
  logic [IDX_W-1:0]   q188_r, q204_r;
  logic [IDX_W-1:0]   count_r, idx_r;
  logic [PLEN_W:0]    off_r;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  action_t            out_action_r;
  logic [IDX_W-1:0]   out_idx_r, out_count_r;
  logic               out_null_r, out_ok_r, out_eflag_r, out_last_r;
  logic [PLEN_W-1:0]  out_src_r;
  logic [SIZE_W-1:0]  out_size_r;
  logic [HLEN_W-1:0]  out_hlen_r;
  logic [SEQ_W-1:0]   out_max_r;

  // Decode terms
  logic               nflag, eflag, is_rist, stale, ahead;
  logic [SIZE_W-1:0]  flag_size;
  logic [NPD_W-1:0]   npd;
  logic [2:0]         ndel;
  logic [SEQ_W-1:0]   ext_seq;
  logic [SEQ_W:0]     diff;
  logic [HLEN_W-1:0]  hstrip;

  // Plan and entry terms
  logic               zero_len, size_bad, pick188, div_done;
  logic [SIZE_W-1:0]  size_sel;
  logic [IDX_W-1:0]   q_sel;
  logic [IDX_W:0]     count_raw;
  logic [IDX_W-1:0]   count_sel;
  logic [7:0]         del_vec;
  logic               is_del, copy_ok, last_entry;
  logic [PLEN_W+1:0]  end_off;
  logic [IDX_W:0]     idx_inc;

  assign nflag     = byte0_r[7];
  assign eflag     = byte0_r[6];
  assign flag_size = byte1_r[7] ? TS_SIZE_LONG : TS_SIZE_SHORT;
  assign npd       = byte1_r[NPD_W-1:0];
  assign is_rist   = has_ext_r && (profile_r == RIST_PROFILE) &&
                     (words_r == RIST_EXT_WORDS);
  assign ext_seq   = {seqh_r, seq_r};
  assign diff      = {1'b0, max_r} - {1'b0, ext_seq};
  // no borrow and above STALE_LIMIT: packet is more than 32767 behind the running maximum
  assign stale     = eflag && !diff[SEQ_W] && (diff[SEQ_W-1:0] > STALE_LIMIT);
  assign ahead     = diff[SEQ_W];
  assign hstrip    = (hlen_r >= EXT_HDR_BYTES) ? hlen_r - EXT_HDR_BYTES : '0;

  always_comb begin
    ndel = '0;
    for (int i = 0; i < NPD_W; i++) begin
      ndel = ndel + {2'b00, npd[i]};
    end
  end

  // Deleted-packet bits run MSB first: entry 0 owns bit 6.
  always_comb begin
    del_vec = '0;
    for (int i = 0; i < NPD_W; i++) begin
      del_vec[i] = npd[NPD_W-1-i];
    end
  end

  assign div_done  = (rem188_r < PLEN_W'(TS_SIZE_SHORT)) &&
                     (rem204_r < PLEN_W'(TS_SIZE_LONG));
  assign zero_len  = (plen_r == '0);
  assign size_bad  = !zero_len && (rem188_r != '0) && (rem204_r != '0);
  assign pick188   = zero_len ? !byte1_r[7] : (rem188_r == '0);
  assign size_sel  = pick188 ? TS_SIZE_SHORT : TS_SIZE_LONG;
  assign q_sel     = pick188 ? q188_r : q204_r;
  assign count_raw = {1'b0, q_sel} + (IDX_W+1)'(ndel);
  assign count_sel = (count_raw > (IDX_W+1)'(MAX_TS_ENTRIES)) ? MAX_TS_ENTRIES
                                                                : count_raw[IDX_W-1:0];

  assign is_del     = (idx_r < IDX_W'(NPD_W)) && del_vec[idx_r[2:0]];
  assign end_off    = {1'b0, off_r} + (PLEN_W+2)'(size_r);
  assign copy_ok    = end_off <= (PLEN_W+2)'(plen_r);
  assign idx_inc    = {1'b0, idx_r} + (IDX_W+1)'(1);
  assign last_entry = (idx_inc == {1'b0, count_r});

  // Hold the input closed while reset is asserted.
  assign in_chan.ready     = cmd.take && rst_n;
  assign status.in_fire    = cmd.take && rst_n && in_chan.valid;
  assign status.single     = !is_rist || stale || !(nflag && (ndel != '0));
  assign status.div_done   = div_done;
  assign status.size_bad   = size_bad;
  assign status.out_free   = !out_valid_r || out_chan.ready;
  assign status.last_entry = last_entry;

  // Request latch
  always_ff @(posedge clk) begin
    if (status.in_fire) begin
      has_ext_r <= in_chan.has_extension;
      profile_r <= in_chan.ext_profile;
      words_r   <= in_chan.ext_words;
      byte0_r   <= in_chan.ext_byte0;
      byte1_r   <= in_chan.ext_byte1;
      seqh_r    <= in_chan.seq_high;
      seq_r     <= in_chan.rtp_seq;
      plen_r    <= in_chan.payload_len;
      hlen_r    <= in_chan.header_len;
    end
  end

  // Sequence state: flag follows every one-word RIST extension, max only grows
  always_comb begin
    max_nxt   = max_r;
    eflag_nxt = eflag_r;
    if (cmd.decode && is_rist) begin
      eflag_nxt = eflag;
      if (eflag && !stale && ahead) max_nxt = ext_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= '0;
      eflag_r <= 1'b0;
    end else begin
      max_r   <= max_nxt;
      eflag_r <= eflag_nxt;
    end
  end

  // Divider and entry walker
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      kind_r   <= !is_rist ? ACT_PASS : (stale ? ACT_DROP : ACT_STRIP);
      size_r   <= flag_size;
      rem188_r <= plen_r;
      rem204_r <= plen_r;
      q188_r   <= '0;
      q204_r   <= '0;
    end
    if (cmd.div_step) begin
      if (rem188_r >= PLEN_W'(TS_SIZE_SHORT)) begin
        rem188_r <= rem188_r - PLEN_W'(TS_SIZE_SHORT);
        q188_r   <= q188_r + IDX_W'(1);
      end
      if (rem204_r >= PLEN_W'(TS_SIZE_LONG)) begin
        rem204_r <= rem204_r - PLEN_W'(TS_SIZE_LONG);
        q204_r   <= q204_r + IDX_W'(1);
      end
    end
    if (cmd.plan) begin
      size_r  <= size_sel;
      count_r <= count_sel;
      idx_r   <= '0;
      off_r   <= '0;
    end
    if (cmd.emit_entry) begin
      idx_r <= idx_inc[IDX_W-1:0];
      if (!is_del) off_r <= off_r + (PLEN_W+1)'(size_r);
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_single || cmd.emit_entry) out_valid_nxt = 1'b1;
    else if (out_chan.ready)               out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_single) begin
      out_action_r <= kind_r;
      out_idx_r    <= '0;
      out_null_r   <= 1'b0;
      out_src_r    <= '0;
      out_ok_r     <= 1'b0;
      out_size_r   <= (kind_r == ACT_STRIP) ? size_r : '0;
      out_count_r  <= '0;
      out_hlen_r   <= (kind_r == ACT_STRIP) ? hstrip : '0;
      out_max_r    <= max_r;
      out_eflag_r  <= eflag_r;
      out_last_r   <= 1'b1;
    end else if (cmd.emit_entry) begin
      out_action_r <= ACT_ENTRY;
      out_idx_r    <= idx_r;
      out_null_r   <= is_del;
      out_src_r    <= (!is_del && copy_ok) ? off_r[PLEN_W-1:0] : '0;
      out_ok_r     <= !is_del && copy_ok;
      out_size_r   <= size_r;
      out_count_r  <= count_r;
      out_hlen_r   <= hstrip;
      out_max_r    <= max_r;
      out_eflag_r  <= eflag_r;
      out_last_r   <= last_entry;
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.action              = out_action_r;
  assign out_chan.ts_index            = out_idx_r;
  assign out_chan.is_null             = out_null_r;
  assign out_chan.copy_offset         = out_src_r;
  assign out_chan.copy_ok             = out_ok_r;
  assign out_chan.ts_size             = out_size_r;
  assign out_chan.packet_count        = out_count_r;
  assign out_chan.stripped_header_len = out_hlen_r;
  assign out_chan.max_seq_seen        = out_max_r;
  assign out_chan.ext_seq_seen        = out_eflag_r;
  assign out_chan.last                = out_last_r;

  // A foreign packet leaves the sequence state alone.
  a_foreign_no_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decode && !is_rist |=> $stable(max_r) && $stable(eflag_r))
    else $error("sequence state changed on a non-RIST packet");

  // The running maximum never falls.
  a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decode |=> max_r >= $past(max_r))
    else $error("max sequence decreased");

  // A valid copy never reaches past the payload.
  a_copy_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_entry && !is_del && copy_ok |=>
      (12'(out_src_r) + 12'(out_size_r)) <= 12'(plen_r))
    else $error("copy offset runs past payload");

endmodule

// ===== rtl/rist_null_packet_restore_planner.sv =====
// Top level of the RIST null-packet restore planner.
// Depends on rnpr_pkg, rnpr_if, rnpr_ctrl and rnpr_dp.

// The planner takes the header summary of one RTP packet per request and
// answers with one or more result items on the output channel. A packet
// without a one-word RIST extension (profile "RI") passes with a single
// pass result. A RIST packet with the E flag forms a 32-bit extended
// sequence number; one more than 32767 behind the largest seen is dropped
// with a single drop result, otherwise the largest is advanced. A RIST
// packet whose N flag is set and whose deleted-packet bits are not all zero
// is restored: the TS size follows the payload length when that is a
// multiple of 188 or 204, the entry count is payload/size plus the number
// of deleted bits (capped at 14), and one entry per TS packet comes out,
// either a regenerated null packet or a payload copy offset with a valid
// flag; the last entry carries last. Entries from index 7 on are never
// null. Every other RIST packet, and a restore whose payload length fits
// neither TS size, gets a single strip result. The block handles one
// request at a time. A single-result request passes through decode and
// has its result loaded once the output register is free; a restore runs
// the size divider, one subtract per cycle, and then the entry walker,
// one entry per cycle while the output register is free. The output
// register lets the next request be accepted while the final result
// still waits for the sink. The input is held closed while reset is
// asserted.
module rist_null_packet_restore_planner (
  input  logic       clk,
  input  logic       rst_n,
  rnpr_in_if.sink    in_chan,
  rnpr_out_if.source out_chan
);
  import rnpr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: idle -> decode -> single answer, or decode -> divide -> walk entries (single answer if size bad)
  rnpr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  // Datapath: holds the request, sequence state and output register
  rnpr_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule
